// ===== design/irsl_pkg.sv =====
package irsl_pkg;

	localparam int unsigned POS_W = 23;
	localparam int unsigned OFF_W = 22;
	localparam logic [POS_W-1:0] HDR_LEN = 23'd16;
	localparam logic [POS_W-1:0] HDR_LAST = 23'd15;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef enum logic [2:0] {
		REG_HEADER  = 3'd0,
		REG_TRAINER = 3'd1,
		REG_PRG     = 3'd2,
		REG_CHR     = 3'd3,
		REG_PAST    = 3'd4,
		REG_REJECT  = 3'd5
	} region_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_OLD_FMT   = 3'd2,
		ST_NES20     = 3'd3,
		ST_MAPPER    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MIR_HORIZ = 2'd0,
		MIR_VERT  = 2'd1,
		MIR_FOUR  = 2'd2
	} mir_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		region_t          region;
		logic [OFF_W-1:0] region_offset;
		logic             header_done;
		status_t          status;
		mir_t             mirroring;
		logic             has_trainer;
		logic             battery_ram;
		logic [7:0]       mapper_number;
		logic [7:0]       prg_banks;
		logic [7:0]       chr_banks;
		logic [7:0]       prg_ram_banks;
	} out_item_t;

	typedef struct packed {
		logic             hdr_ok;
		logic [POS_W-1:0] prg_start;
		logic [POS_W-1:0] chr_start;
		logic [POS_W-1:0] chr_end;
	} bounds_t;

	typedef struct packed {
		status_t    status;
		mir_t       mirroring;
		logic       has_trainer;
		logic       battery_ram;
		logic [7:0] mapper_number;
		logic [7:0] prg_banks;
		logic [7:0] chr_banks;
		logic [7:0] prg_ram_banks;
	} hdr_info_t;

endpackage

// ===== design/ines_rom_stream_loader.sv =====
// Parses an iNES 1.0 cartridge image streamed one byte per transaction and
// returns one tagged result per byte: header, trainer, PRG, CHR, past end or
// rejected, with the byte's offset inside that region. The header is decoded
// on byte 15 (header_done), and from then on the decoded fields and status are
// shown on every result. file_start on a byte restarts the parse at that byte;
// after reset the first byte is taken as byte 0. Throughput is one byte per
// clock while the result is not stalled: a byte is taken into an input
// register, classified against the byte counter and the region bounds
// latched at header decode, and the result is registered.
// The input register lets one more byte be taken while a result is stalled.
module ines_rom_stream_loader (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  irsl_pkg::in_item_t   src_item,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output irsl_pkg::out_item_t  dst_item
);
	import irsl_pkg::*;

	in_item_t         item_s1;
	logic             valid_s1;
	logic [POS_W-1:0] pos_q;
	out_item_t        result_q;
	logic             dst_valid_q;

	logic             accept;
	logic             advance;
	logic [POS_W-1:0] eff_pos;
	logic             at_last;
	logic             show_fields;
	hdr_info_t        info;
	bounds_t          bounds;
	region_t          region;
	logic [OFF_W-1:0] region_offset;
	out_item_t        result_d;

	assign advance   = valid_s1 && (!dst_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;
	assign accept    = src_valid && !src_stall;

	assign eff_pos     = item_s1.file_start ? '0 : pos_q;
	assign at_last     = (eff_pos == HDR_LAST);
	assign show_fields = (eff_pos >= HDR_LAST);

	irsl_hdr u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (advance && (eff_pos < HDR_LEN)),
		.idx     (eff_pos[3:0]),
		.wr_byte (item_s1.data_byte),
		.at_last (at_last),
		.info    (info),
		.bounds  (bounds)
	);

	irsl_tag u_tag (
		.pos           (eff_pos),
		.bounds        (bounds),
		.region        (region),
		.region_offset (region_offset)
	);

	always_comb begin
		result_d               = '0;
		result_d.region        = region;
		result_d.region_offset = region_offset;
		result_d.header_done   = at_last;
		if (show_fields) begin
			result_d.status        = info.status;
			result_d.mirroring     = info.mirroring;
			result_d.has_trainer   = info.has_trainer;
			result_d.battery_ram   = info.battery_ram;
			result_d.mapper_number = info.mapper_number;
			result_d.prg_banks     = info.prg_banks;
			result_d.chr_banks     = info.chr_banks;
			result_d.prg_ram_banks = info.prg_ram_banks;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= src_item;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dst_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				dst_valid_q <= 1'b1;
				pos_q       <= (eff_pos == POS_MAX) ? eff_pos : eff_pos + 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = result_q;

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid_q && result_q.header_done |->
			result_q.region == REG_HEADER &&
			result_q.region_offset == HDR_LAST[OFF_W-1:0])
		else $error("header_done off the last header byte");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid_q && result_q.status != ST_OK |->
			result_q.region == REG_HEADER || result_q.region == REG_REJECT)
		else $error("data region tagged after a header error");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && dst_valid_q && dst_stall)
		else $error("input stalled with room in the pipeline");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.file_start && pos_q != POS_MAX |=>
			pos_q == $past(pos_q) + 1'b1)
		else $error("byte counter did not step");

endmodule

// ===== design/irsl_hdr.sv =====
module irsl_hdr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [3:0]           idx,
	input  logic [7:0]           wr_byte,
	input  logic                 at_last,
	output irsl_pkg::hdr_info_t  info,
	output irsl_pkg::bounds_t    bounds
);
	import irsl_pkg::*;

	localparam logic [3:0] LAST_IDX = 4'd15;
	localparam logic [POS_W-1:0] TRAINER_END = 23'd528;

	logic [7:0]       hdr_q [16];
	status_t          error_q;
	logic             hdr_ok_q;
	logic [POS_W-1:0] prg_start_q;
	logic [POS_W-1:0] chr_start_q;
	logic [POS_W-1:0] chr_end_q;

	status_t          dec_status;
	logic [7:0]       mapper;
	logic [POS_W-1:0] prg_start_d;
	logic [POS_W-1:0] chr_start_d;
	logic [POS_W-1:0] chr_end_d;
	logic             dec_en;

	// byte 15 arrives on wr_byte and is decoded together with the stored bytes
	assign mapper = {hdr_q[7][7:4], hdr_q[6][7:4]};

	always_comb begin
		if (hdr_q[0] != 8'h4E || hdr_q[1] != 8'h45 || hdr_q[2] != 8'h53 ||
		    hdr_q[3] != 8'h1A) begin
			dec_status = ST_BAD_MAGIC;
		end else if (hdr_q[7][3:2] == 2'b10) begin
			dec_status = ST_NES20;
		end else if (hdr_q[7][3:2] != 2'b00 || hdr_q[12] != 8'h00 ||
		             hdr_q[13] != 8'h00 || hdr_q[14] != 8'h00 || wr_byte != 8'h00) begin
			dec_status = ST_OLD_FMT;
		end else if (mapper != 8'h00) begin
			dec_status = ST_MAPPER;
		end else begin
			dec_status = ST_OK;
		end
	end

	assign prg_start_d = hdr_q[6][2] ? TRAINER_END : HDR_LEN;
	assign chr_start_d = prg_start_d | {1'b0, hdr_q[4], 14'd0};
	assign chr_end_d   = chr_start_d + {2'b00, hdr_q[5], 13'd0};
	assign dec_en      = wr && (idx == LAST_IDX);

	always_ff @(posedge clk) begin
		if (wr) begin
			hdr_q[idx] <= wr_byte;
		end
		if (dec_en) begin
			prg_start_q <= prg_start_d;
			chr_start_q <= chr_start_d;
			chr_end_q   <= chr_end_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q  <= ST_OK;
			hdr_ok_q <= 1'b0;
		end else if (dec_en) begin
			error_q  <= dec_status;
			hdr_ok_q <= (dec_status == ST_OK);
		end
	end

	always_comb begin
		info.status        = at_last ? dec_status : error_q;
		if (hdr_q[6][3]) begin
			info.mirroring = MIR_FOUR;
		end else if (hdr_q[6][0]) begin
			info.mirroring = MIR_VERT;
		end else begin
			info.mirroring = MIR_HORIZ;
		end
		info.has_trainer   = hdr_q[6][2];
		info.battery_ram   = hdr_q[6][1];
		info.mapper_number = mapper;
		info.prg_banks     = hdr_q[4];
		info.chr_banks     = hdr_q[5];
		info.prg_ram_banks = hdr_q[8];
	end

	assign bounds.hdr_ok    = hdr_ok_q;
	assign bounds.prg_start = prg_start_q;
	assign bounds.chr_start = chr_start_q;
	assign bounds.chr_end   = chr_end_q;

endmodule

// ===== design/irsl_tag.sv =====
module irsl_tag (
	input  logic [irsl_pkg::POS_W-1:0] pos,
	input  irsl_pkg::bounds_t          bounds,
	output irsl_pkg::region_t          region,
	output logic [irsl_pkg::OFF_W-1:0] region_offset
);
	import irsl_pkg::*;

	logic [POS_W-1:0] d_hdr;
	logic [POS_W-1:0] d_prg;
	logic [POS_W-1:0] d_chr;
	logic [POS_W-1:0] d_end;

	function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W-1:0] v);
		return v[POS_W-1] ? {OFF_W{1'b1}} : v[OFF_W-1:0];
	endfunction

	assign d_hdr = pos - HDR_LEN;
	assign d_prg = pos - bounds.prg_start;
	assign d_chr = pos - bounds.chr_start;
	assign d_end = pos - bounds.chr_end;

	always_comb begin
		if (pos < HDR_LEN) begin
			region        = REG_HEADER;
			region_offset = pos[OFF_W-1:0];
		end else if (!bounds.hdr_ok) begin
			region        = REG_REJECT;
			region_offset = sat_off(d_hdr);
		end else if (pos < bounds.prg_start) begin
			region        = REG_TRAINER;
			region_offset = sat_off(d_hdr);
		end else if (pos < bounds.chr_start) begin
			region        = REG_PRG;
			region_offset = sat_off(d_prg);
		end else if (pos < bounds.chr_end) begin
			region        = REG_CHR;
			region_offset = sat_off(d_chr);
		end else begin
			region        = REG_PAST;
			region_offset = sat_off(d_end);
		end
	end

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import irsl_pkg::*;

	typedef logic [15:0][7:0] hdr_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
	typedef enum {HDR_GOOD, HDR_BAD_MAGIC, HDR_BAD_VERSION, HDR_BAD_TAIL, HDR_BAD_MAPPER}
		defect_e;

	localparam logic [31:0] INES_MAGIC = 32'h4E45531A;
	localparam logic [7:0] VER_MASK = 8'h0C;
	localparam logic [7:0] VER_NES20 = 8'h08;
	localparam logic [7:0] VER_ARCHAIC = 8'h04;
	localparam int unsigned HDR_BYTES = 16;
	localparam int unsigned TRAINER_END = 528;
	localparam int unsigned TRAINER_BYTES = 512;
	localparam int unsigned PRG_BANK = 16384;
	localparam int unsigned CHR_BANK = 8192;
	localparam int unsigned OFF_LIMIT = 4194303;

	class rom_parse_scoreboard;
		out_item_t expected_q[$];
		logic [POS_W-1:0] pos;
		hdr_t hdr;
		status_t hdr_status;
		bit hdr_accepted;
		int errors;
		int checked;
		int region_hits[6];

		function new();
			pos = '0;
			hdr = '0;
			hdr_status = ST_OK;
			hdr_accepted = 1'b0;
			errors = 0;
			checked = 0;
			foreach (region_hits[i]) region_hits[i] = 0;
		endfunction

		function status_t decode_header();
			logic [7:0] ver;
			logic [7:0] mapper;
			ver = hdr[7] & VER_MASK;
			mapper = {hdr[7][7:4], hdr[6][7:4]};
			if ({hdr[0], hdr[1], hdr[2], hdr[3]} != INES_MAGIC)
				return ST_BAD_MAGIC;
			if (ver == VER_NES20)
				return ST_NES20;
			if (ver != 8'h00 || {hdr[12], hdr[13], hdr[14], hdr[15]} != 32'h0)
				return ST_OLD_FMT;
			if (mapper != 8'h00)
				return ST_MAPPER;
			return ST_OK;
		endfunction

		function logic [OFF_W-1:0] clip_offset(input int unsigned v);
			int unsigned c;
			c = (v > OFF_LIMIT) ? OFF_LIMIT : v;
			return c[OFF_W-1:0];
		endfunction

		function void note_input(input in_item_t it);
			out_item_t r;
			int unsigned p;
			int unsigned prg_start;
			int unsigned chr_start;
			int unsigned chr_end;
			r = '0;
			if (it.file_start) begin
				pos = '0;
				hdr_status = ST_OK;
				hdr_accepted = 1'b0;
			end
			p = 32'(pos);
			if (p < HDR_BYTES) begin
				hdr[p[3:0]] = it.data_byte;
				r.region = REG_HEADER;
				r.region_offset = clip_offset(p);
				if (p == HDR_BYTES - 1) begin
					r.header_done = 1'b1;
					hdr_status = decode_header();
					hdr_accepted = (hdr_status == ST_OK);
				end
			end else if (!hdr_accepted) begin
				r.region = REG_REJECT;
				r.region_offset = clip_offset(p - HDR_BYTES);
			end else begin
				prg_start = hdr[6][2] ? TRAINER_END : HDR_BYTES;
				chr_start = prg_start + hdr[4] * PRG_BANK;
				chr_end = chr_start + hdr[5] * CHR_BANK;
				if (p < prg_start) begin
					r.region = REG_TRAINER;
					r.region_offset = clip_offset(p - HDR_BYTES);
				end else if (p < chr_start) begin
					r.region = REG_PRG;
					r.region_offset = clip_offset(p - prg_start);
				end else if (p < chr_end) begin
					r.region = REG_CHR;
					r.region_offset = clip_offset(p - chr_start);
				end else begin
					r.region = REG_PAST;
					r.region_offset = clip_offset(p - chr_end);
				end
			end
			if (pos != POS_MAX)
				pos = pos + 1'b1;
			if (p >= HDR_BYTES - 1) begin
				r.status = hdr_status;
				r.mirroring = hdr[6][3] ? MIR_FOUR : (hdr[6][0] ? MIR_VERT : MIR_HORIZ);
				r.has_trainer = hdr[6][2];
				r.battery_ram = hdr[6][1];
				r.mapper_number = {hdr[7][7:4], hdr[6][7:4]};
				r.prg_banks = hdr[4];
				r.chr_banks = hdr[5];
				r.prg_ram_banks = hdr[8];
			end
			expected_q.push_back(r);
		endfunction

		function void compare_field(input string name, input logic [31:0] e,
				input logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			end
		endfunction

		function void check_result(input out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			region_hits[want.region]++;
			compare_field("region", want.region, got.region);
			compare_field("region_offset", want.region_offset, got.region_offset);
			compare_field("header_done", want.header_done, got.header_done);
			compare_field("status", want.status, got.status);
			compare_field("mirroring", want.mirroring, got.mirroring);
			compare_field("has_trainer", want.has_trainer, got.has_trainer);
			compare_field("battery_ram", want.battery_ram, got.battery_ram);
			compare_field("mapper_number", want.mapper_number, got.mapper_number);
			compare_field("prg_banks", want.prg_banks, got.prg_banks);
			compare_field("chr_banks", want.chr_banks, got.chr_banks);
			compare_field("prg_ram_banks", want.prg_ram_banks, got.prg_ram_banks);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	in_item_t src_item = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	out_item_t dst_item;

	rom_parse_scoreboard sb = new();
	int burst_left = 0;
	int bytes_sent = 0;
	int images = 0;
	rx_mode_e rx_mode = RX_FREE;
	int unsigned rx_count = 0;

	ines_rom_stream_loader uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item(dst_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd50_000_000);
		$display("FAIL ines_rom_stream_loader");
		$finish;
	end

	// receiver stall pattern, the mode is redrawn at random from the four modes
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			sb.check_result(dst_item);
		rx_count++;
		if (rx_count % 64 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_FREE: dst_stall <= 1'b0;
			RX_LIGHT: dst_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: dst_stall <= ($urandom_range(0, 3) != 0);
			default: dst_stall <= (rx_count % 5 < 2);
		endcase
	end

	function automatic hdr_t ines_header(input logic [7:0] prg, chr, f6, f7, ram);
		hdr_t h;
		h = '0;
		{h[0], h[1], h[2], h[3]} = INES_MAGIC;
		h[4] = prg;
		h[5] = chr;
		h[6] = f6;
		h[7] = f7;
		h[8] = ram;
		return h;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fs);
		in_item_t it;
		it.data_byte = b;
		it.file_start = fs;
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (src_stall);
		sb.note_input(it);
		bytes_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				src_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	task automatic send_image(input hdr_t h, input int body_len, input bit restart,
			input bit noisy);
		images++;
		for (int i = 0; i < HDR_BYTES; i++)
			send_byte(h[i], restart && i == 0);
		for (int i = 0; i < body_len; i++)
			send_byte(8'($urandom_range(0, 255)), noisy && $urandom_range(0, 63) == 0);
	endtask

	initial begin
		hdr_t h;
		int rnd_start;
		int body_len;
		defect_e defect;
		logic [7:0] prg;
		logic [7:0] chr;
		logic [7:0] f6;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first image after reset without file_start
		send_image(ines_header(8'h00, 8'h00, 8'h03, 8'h00, 8'hFF), 3, 1'b0, 1'b0);
		// restart part way into a header
		h = ines_header(8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
		images++;
		for (int i = 0; i < 7; i++)
			send_byte(h[i], i == 0);
		// whole trainer into the first PRG bytes; four screen wins over vertical
		send_image(ines_header(8'h01, 8'h01, 8'h0D, 8'h00, 8'h01),
			TRAINER_BYTES + 3, 1'b1, 1'b0);
		send_image(ines_header(8'hFF, 8'hFF, 8'h02, 8'h03, 8'h00), 5, 1'b1, 1'b0);
		h = ines_header(8'h00, 8'h00, 8'h00, VER_NES20, 8'h00);
		h[3] = 8'h1B;
		send_image(h, 3, 1'b1, 1'b0);
		h = ines_header(8'h00, 8'h00, 8'h00, VER_NES20, 8'h00);
		h[12] = 8'h80;
		send_image(h, 2, 1'b1, 1'b0);
		send_image(ines_header(8'h00, 8'h00, 8'h00, VER_ARCHAIC, 8'h00), 2, 1'b1, 1'b0);
		send_image(ines_header(8'h00, 8'h00, 8'h00, VER_MASK, 8'h00), 1, 1'b1, 1'b0);
		h = ines_header(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		h[15] = 8'h01;
		send_image(h, 2, 1'b1, 1'b0);
		send_image(ines_header(8'h00, 8'h00, 8'hF0, 8'hF0, 8'h00), 2, 1'b1, 1'b0);
		send_image(ines_header(8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 4, 1'b1, 1'b0);
		send_image(ines_header(8'h00, 8'h01, 8'h01, 8'h00, 8'h00), 4, 1'b1, 1'b0);

		rnd_start = bytes_sent;
		while (bytes_sent - rnd_start < 150) begin
			f6 = 8'($urandom_range(0, 15));
			prg = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			chr = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			h = ines_header(prg, chr, f6, 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)));
			h[9] = 8'($urandom_range(0, 255));
			h[10] = 8'($urandom_range(0, 255));
			h[11] = 8'($urandom_range(0, 255));
			defect = ($urandom_range(0, 3) == 0) ? defect_e'($urandom_range(1, 4)) : HDR_GOOD;
			case (defect)
				HDR_BAD_MAGIC: h[2'($urandom_range(0, 3))] ^= 8'($urandom_range(1, 255));
				HDR_BAD_VERSION: h[7][3:2] = 2'($urandom_range(1, 3));
				HDR_BAD_TAIL: h[4'($urandom_range(12, 15))] = 8'($urandom_range(1, 255));
				HDR_BAD_MAPPER: {h[7][7:4], h[6][7:4]} = 8'($urandom_range(1, 255));
				default: ;
			endcase
			body_len = $urandom_range(0, 40);
			send_image(h, body_len, $urandom_range(0, 9) != 0, 1'b1);
		end
		src_valid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Streamed %0d images, %0d bytes; %0d results checked", images,
			bytes_sent, sb.checked);
		$display("Per region: header %0d, trainer %0d, PRG %0d, CHR %0d, past %0d, rej %0d",
			sb.region_hits[REG_HEADER], sb.region_hits[REG_TRAINER],
			sb.region_hits[REG_PRG], sb.region_hits[REG_CHR],
			sb.region_hits[REG_PAST], sb.region_hits[REG_REJECT]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS ines_rom_stream_loader");
		else
			$display("FAIL ines_rom_stream_loader");
		$finish;
	end
endmodule
